### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that carry concurrent checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define DMN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

### hw/rtl/dmn_pkg.sv
// Shared types, codes and default sizes for the distributed mutex node.
// No dependencies.
package dmn_pkg;

  localparam int MAX_NODES_DEF   = 16;
  localparam int CLOCK_WIDTH_DEF = 32;

  localparam int ACTION_W  = 3;
  localparam int PEER_W    = 4;
  localparam int STAMP_W   = 32;
  localparam int KIND_W    = 2;
  localparam int MODE_W    = 2;
  localparam int NODE_ID_W = 4;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REQUEST   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PEER_REQ  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_PEER_REP  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REQ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CS   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic apply;
    logic step;
    logic emit_msg;
    logic emit_status;
  } dmn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_left;
    logic hit;
    logic last_hit;
  } dmn_sts_t;

endpackage

### hw/rtl/dmn_if.sv
// Valid/ready channel interfaces for events in and results out.
// Depends on dmn_pkg.
interface dmn_evt_if import dmn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PEER_W-1:0]   peer;
  logic [STAMP_W-1:0]  stamp;

  modport source (output valid, action, peer, stamp, input ready);
  modport sink   (input valid, action, peer, stamp, output ready);
endinterface

interface dmn_res_if import dmn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  send_kind;
  logic [PEER_W-1:0]  dest;
  logic [STAMP_W-1:0] stamp_out;
  logic [MODE_W-1:0]  mode;
  logic               last;

  modport source (output valid, send_kind, dest, stamp_out, mode, last, input ready);
  modport sink   (input valid, send_kind, dest, stamp_out, mode, last, output ready);
endinterface

### hw/rtl/dmn_datapath.sv
// Datapath of the mutex node: configuration, protocol state, message scan
// and the output register. Depends on dmn_pkg; driven by dmn_ctrl commands.
module dmn_datapath import dmn_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int CLOCK_WIDTH = CLOCK_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [PEER_W-1:0]     peer_i,
  input  logic [STAMP_W-1:0]    stamp_i,
  input  dmn_cmd_t              cmd_i,
  output dmn_sts_t              sts_o,
  output logic [KIND_W-1:0]     send_kind_o,
  output logic [PEER_W-1:0]     dest_o,
  output logic [STAMP_W-1:0]    stamp_out_o,
  output logic [MODE_W-1:0]     mode_o,
  output logic                  last_o
);

  localparam int IdxW = $clog2(MAX_NODES);
  localparam int CntW = ($clog2(MAX_NODES + 1) > COUNT_W) ? $clog2(MAX_NODES + 1) : COUNT_W;

  logic [NODE_ID_W-1:0]   node_id_q;
  logic [COUNT_W-1:0]     node_count_q;

  logic [CLOCK_WIDTH-1:0] clock_q, clock_d;
  logic [CLOCK_WIDTH-1:0] req_stamp_q, req_stamp_d;
  logic [MODE_W-1:0]      mode_q, mode_d;
  logic [IdxW-1:0]        awaited_q, awaited_d;
  logic [MAX_NODES-1:0]   deferred_q, deferred_d;
  logic [MAX_NODES-1:0]   run_mask_q, run_mask_d;
  logic [KIND_W-1:0]      run_kind_q, run_kind_d;
  logic [IdxW-1:0]        idx_q;

  logic [KIND_W-1:0]      kind_q;
  logic [PEER_W-1:0]      dest_q;
  logic [STAMP_W-1:0]     stamp_out_q;
  logic [MODE_W-1:0]      omode_q;
  logic                   last_q;

  logic [CntW-1:0]        n_eff, id_w, pw, nc;
  logic                   outside;
  logic [MAX_NODES-1:0]   peer_mask, peer_oh, idx_oh, rest_mask;
  logic                   peer_ok;
  logic [CLOCK_WIDTH-1:0] s_w, base, sum;
  logic [1:0]             inc;
  logic                   merge, grant;

  // Effective node count and peer set.
  always_comb begin
    logic [CntW-1:0] iw;
    nc = CntW'(node_count_q);
    if (nc == '0) begin
      n_eff = CntW'(1);
    end else if (nc > CntW'(MAX_NODES)) begin
      n_eff = CntW'(MAX_NODES);
    end else begin
      n_eff = nc;
    end
    id_w    = CntW'(node_id_q);
    pw      = CntW'(peer_i);
    outside = (id_w >= n_eff);
    for (int i = 0; i < MAX_NODES; i++) begin
      iw = CntW'(i);
      peer_mask[i] = outside ? (iw < n_eff - CntW'(1)) : ((iw < n_eff) && (iw != id_w));
      peer_oh[i]   = (iw == pw);
      idx_oh[i]    = (IdxW'(i) == idx_q);
    end
    peer_ok = outside ? (pw < n_eff - CntW'(1)) : ((pw < n_eff) && (pw != id_w));
  end

  assign s_w   = CLOCK_WIDTH'(stamp_i);
  assign grant = (mode_q == MODE_IDLE) ||
                 ((mode_q == MODE_REQ) &&
                  ((s_w < req_stamp_q) || ((s_w == req_stamp_q) && (peer_i < node_id_q))));

  // Clock increment for the event; a granted peer request advances twice.
  always_comb begin
    inc   = 2'd0;
    merge = 1'b0;
    unique case (action_i)
      ACT_TICK:     inc = 2'd1;
      ACT_REQUEST:  inc = (mode_q == MODE_IDLE) ? 2'd1 : 2'd0;
      ACT_RELEASE:  inc = (mode_q == MODE_CS) ? 2'd1 : 2'd0;
      ACT_PEER_REQ: begin
        merge = peer_ok;
        inc   = peer_ok ? (grant ? 2'd2 : 2'd1) : 2'd0;
      end
      ACT_PEER_REP: begin
        merge = peer_ok;
        inc   = peer_ok ? 2'd1 : 2'd0;
      end
      default:      inc = 2'd0;
    endcase
  end

  assign base = (merge && (s_w > clock_q)) ? s_w : clock_q;
  assign sum  = base + CLOCK_WIDTH'(inc);

  // Next protocol state and the run of messages to send.
  always_comb begin
    clock_d     = sum;
    req_stamp_d = req_stamp_q;
    mode_d      = mode_q;
    awaited_d   = awaited_q;
    deferred_d  = deferred_q;
    run_mask_d  = '0;
    run_kind_d  = KIND_REQ;
    unique case (action_i)
      ACT_REQUEST: begin
        if (mode_q == MODE_IDLE) begin
          req_stamp_d = sum;
          // Every node but this one is a peer, so n-1 replies are due.
          mode_d      = (n_eff == CntW'(1)) ? MODE_CS : MODE_REQ;
          awaited_d   = IdxW'(n_eff - CntW'(1));
          run_mask_d  = peer_mask;
        end
      end
      ACT_RELEASE: begin
        if (mode_q == MODE_CS) begin
          mode_d     = MODE_IDLE;
          run_mask_d = deferred_q & peer_mask;
          run_kind_d = KIND_REP;
          deferred_d = '0;
        end
      end
      ACT_PEER_REQ: begin
        if (peer_ok) begin
          run_kind_d = KIND_REP;
          if (grant) begin
            run_mask_d = peer_oh;
          end else begin
            deferred_d = deferred_q | peer_oh;
          end
        end
      end
      ACT_PEER_REP: begin
        if (peer_ok && (mode_q == MODE_REQ) && (awaited_q != '0)) begin
          awaited_d = awaited_q - IdxW'(1);
          if (awaited_q == IdxW'(1)) begin
            mode_d = MODE_CS;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rest_mask      = run_mask_q & ~idx_oh;
  assign sts_o.run_left = |run_mask_q;
  assign sts_o.hit      = |(run_mask_q & idx_oh);
  assign sts_o.last_hit = ~|rest_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= '0;
      node_count_q <= COUNT_W'(1);
      clock_q      <= '0;
      req_stamp_q  <= '0;
      mode_q       <= MODE_IDLE;
      awaited_q    <= '0;
      deferred_q   <= '0;
      run_mask_q   <= '0;
      run_kind_q   <= KIND_NONE;
      idx_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NODE_ID:    node_id_q    <= cfg_data_i[NODE_ID_W-1:0];
          CFG_NODE_COUNT: node_count_q <= cfg_data_i[COUNT_W-1:0];
        endcase
      end
      if (cmd_i.apply) begin
        clock_q     <= clock_d;
        req_stamp_q <= req_stamp_d;
        mode_q      <= mode_d;
        awaited_q   <= awaited_d;
        deferred_q  <= deferred_d;
        run_mask_q  <= run_mask_d;
        run_kind_q  <= run_kind_d;
        idx_q       <= '0;
      end else if (cmd_i.emit_msg) begin
        run_mask_q <= rest_mask;
        idx_q      <= idx_q + IdxW'(1);
      end else if (cmd_i.step) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // Output register; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_msg) begin
      kind_q      <= run_kind_q;
      dest_q      <= PEER_W'(idx_q);
      stamp_out_q <= STAMP_W'(clock_q);
      omode_q     <= mode_q;
      last_q      <= sts_o.last_hit;
    end else if (cmd_i.emit_status) begin
      kind_q      <= KIND_NONE;
      dest_q      <= '0;
      stamp_out_q <= STAMP_W'(clock_q);
      omode_q     <= mode_q;
      last_q      <= 1'b1;
    end
  end

  assign send_kind_o = kind_q;
  assign dest_o      = dest_q;
  assign stamp_out_o = stamp_out_q;
  assign mode_o      = omode_q;
  assign last_o      = last_q;

endmodule

### hw/rtl/dmn_ctrl.sv
// Controller of the mutex node: event handshake, message scan sequencing
// and the output valid flag. Depends on dmn_pkg; drives dmn_datapath.
module dmn_ctrl import dmn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     evt_valid_i,
  output logic     evt_ready_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  input  dmn_sts_t sts_i,
  output dmn_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || res_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (evt_valid_i) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        // An empty run from the start produces a single status transaction.
        if (!sts_i.run_left) begin
          if (out_free) begin
            cmd_o.emit_status = 1'b1;
            state_d           = ST_IDLE;
          end
        end else if (!sts_i.hit) begin
          cmd_o.step = 1'b1;
        end else if (out_free) begin
          cmd_o.emit_msg = 1'b1;
          if (sts_i.last_hit) begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit_msg || cmd_o.emit_status) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign evt_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = out_valid_q;

endmodule

### hw/rtl/distributed_mutex_node.sv
// Distributed mutual exclusion node, one event at a time.
// An event is applied when accepted; a status-only event then gives one status
// transaction, and an event with messages scans one node index per cycle, stalled
// while an untaken result holds the output register. A new event waits for the scan.
// Reset: asynchronous active low; clock, stamps, mode, counts and deferrals clear,
// node_id resets to 0 and node_count to 1.
module distributed_mutex_node import dmn_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int CLOCK_WIDTH = CLOCK_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dmn_evt_if.sink               evt_i,
  dmn_res_if.source             res_o
);

`include "assert_macros.svh"

  dmn_cmd_t           cmd;
  dmn_sts_t           sts;
  logic               evt_ready;
  logic               res_valid;
  logic [KIND_W-1:0]  res_kind;
  logic [PEER_W-1:0]  res_dest;
  logic [STAMP_W-1:0] res_stamp;
  logic [MODE_W-1:0]  res_mode;
  logic               res_last;

  dmn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_i.valid),
    .evt_ready_o (evt_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dmn_datapath #(
    .MAX_NODES   (MAX_NODES),
    .CLOCK_WIDTH (CLOCK_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .action_i    (evt_i.action),
    .peer_i      (evt_i.peer),
    .stamp_i     (evt_i.stamp),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .send_kind_o (res_kind),
    .dest_o      (res_dest),
    .stamp_out_o (res_stamp),
    .mode_o      (res_mode),
    .last_o      (res_last)
  );

  assign evt_i.ready     = evt_ready;
  assign res_o.valid     = res_valid;
  assign res_o.send_kind = res_kind;
  assign res_o.dest      = res_dest;
  assign res_o.stamp_out = res_stamp;
  assign res_o.mode      = res_mode;
  assign res_o.last      = res_last;

  // The output register is never overwritten while it holds an untaken result.
  `DMN_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, (cmd.emit_msg || cmd.emit_status), (!res_valid || res_o.ready))
  // After an accepted event the node is busy and not ready in the following cycle.
  `DMN_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, (evt_i.valid && evt_ready), (!evt_ready))
  // While a run is unfinished no new event is taken.
  `DMN_ASSERT_IMPL(a_run_blocks_input, clk_i, rst_ni, (res_valid && !res_last), (!evt_ready))
  // Request messages only go out while the node is requesting.
  `DMN_ASSERT_IMPL(a_req_mode, clk_i, rst_ni, (res_valid && (res_kind == KIND_REQ)), (res_mode == MODE_REQ))

endmodule

### test/tb_top.sv
// Self-checking testbench for distributed_mutex_node: a scoreboard class predicts the
// message runs of each event and checks them in order against the result channel.
// Depends on dmn_pkg, the dmn_evt_if / dmn_res_if interfaces and the node RTL.
module tb_top import dmn_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PEER_W-1:0]  dest;
    logic [STAMP_W-1:0] stamp_out;
    logic [MODE_W-1:0]  mode;
    logic               last;
  } msg_t;

  typedef int index_q_t[$];

  class mutex_scoreboard;
    logic [NODE_ID_W-1:0]     node_id;
    logic [COUNT_W-1:0]       node_count;
    logic [STAMP_W-1:0]       lclock;
    logic [STAMP_W-1:0]       req_stamp;
    logic [MODE_W-1:0]        mode;
    int unsigned              awaited;
    logic [MAX_NODES_DEF-1:0] deferred;
    msg_t                     expected_msgs[$];
    int                       errors;

    function new();
      node_id    = '0;
      node_count = COUNT_W'(1);
      lclock     = '0;
      req_stamp  = '0;
      mode       = MODE_IDLE;
      awaited    = 0;
      deferred   = '0;
      errors     = 0;
    endfunction

    // An out-of-range node id takes the highest slot, leaving peers 0..n-2.
    function bit is_peer(int i);
      int n;
      n = node_count;
      if (n < 1) n = 1;
      if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
      if (node_id >= n) return i < n - 1;
      return i < n && i != node_id;
    endfunction

    function index_q_t peer_list();
      index_q_t peers;
      for (int i = 0; i < MAX_NODES_DEF; i++) begin
        if (is_peer(i)) peers.push_back(i);
      end
      return peers;
    endfunction

    function msg_t make_msg(logic [KIND_W-1:0] kind, int dest, logic [STAMP_W-1:0] st);
      msg_t m;
      m.kind      = kind;
      m.dest      = PEER_W'(dest);
      m.stamp_out = st;
      m.mode      = MODE_IDLE;
      m.last      = 1'b0;
      return m;
    endfunction

    function void merge_clock(logic [STAMP_W-1:0] st);
      if (st > lclock) lclock = st;
      lclock++;
    endfunction

    function void note_event(logic [ACTION_W-1:0] action, logic [PEER_W-1:0] peer,
                             logic [STAMP_W-1:0] st);
      msg_t run[$];
      bit   grant;
      case (action)
        ACT_TICK: begin
          lclock++;
        end
        ACT_REQUEST: begin
          if (mode == MODE_IDLE) begin
            lclock++;
            req_stamp = lclock;
            mode = MODE_REQ;
            for (int i = 0; i < MAX_NODES_DEF; i++) begin
              if (is_peer(i)) run.push_back(make_msg(KIND_REQ, i, lclock));
            end
            awaited = run.size();
            // With no peers there is nobody to wait for.
            if (run.size() == 0) mode = MODE_CS;
          end
        end
        ACT_RELEASE: begin
          if (mode == MODE_CS) begin
            lclock++;
            mode = MODE_IDLE;
            for (int i = 0; i < MAX_NODES_DEF; i++) begin
              if (deferred[i] && is_peer(i)) run.push_back(make_msg(KIND_REP, i, lclock));
            end
            deferred = '0;
          end
        end
        ACT_PEER_REQ: begin
          if (is_peer(peer)) begin
            merge_clock(st);
            grant = mode == MODE_IDLE ||
                    (mode == MODE_REQ &&
                     (st < req_stamp || (st == req_stamp && peer < node_id)));
            if (grant) begin
              lclock++;
              run.push_back(make_msg(KIND_REP, peer, lclock));
            end else begin
              deferred[peer] = 1'b1;
            end
          end
        end
        ACT_PEER_REP: begin
          if (is_peer(peer)) begin
            merge_clock(st);
            if (mode == MODE_REQ && awaited > 0) begin
              awaited--;
              if (awaited == 0) mode = MODE_CS;
            end
          end
        end
        default: begin
        end
      endcase
      if (run.size() == 0) run.push_back(make_msg(KIND_NONE, 0, lclock));
      foreach (run[j]) begin
        run[j].mode = mode;
        run[j].last = (j == run.size() - 1);
        expected_msgs.push_back(run[j]);
      end
    endfunction

    function void check_result(msg_t got);
      msg_t want;
      if (expected_msgs.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result kind=%0d dest=%0d stamp=%08h mode=%0d last=%0b",
                   got.kind, got.dest, got.stamp_out, got.mode, got.last);
        return;
      end
      want = expected_msgs.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: expected kind=%0d dest=%0d stamp=%08h mode=%0d last=%0b",
                   want.kind, want.dest, want.stamp_out, want.mode, want.last);
          $display("       actual   kind=%0d dest=%0d stamp=%08h mode=%0d last=%0b",
                   got.kind, got.dest, got.stamp_out, got.mode, got.last);
        end
      end
    endfunction

    function int pending();
      return expected_msgs.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dmn_evt_if evt_if ();
  dmn_res_if res_if ();

  distributed_mutex_node DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .evt_i     (evt_if),
    .res_o     (res_if)
  );

  mutex_scoreboard sb = new();
  bit idle_en;
  int sent_items;
  int stall_left;
  int quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: ready drops in random bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready)
        sb.check_result({res_if.send_kind, res_if.dest, res_if.stamp_out, res_if.mode,
                         res_if.last});
      if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Valid stays high across back-to-back transactions; it drops only for a random gap or in settle().
  task automatic send_event(logic [ACTION_W-1:0] action, logic [PEER_W-1:0] peer,
                            logic [STAMP_W-1:0] st);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    evt_if.valid  <= 1'b1;
    evt_if.action <= action;
    evt_if.peer   <= peer;
    evt_if.stamp  <= st;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    sb.note_event(action, peer, st);
    sent_items++;
  endtask

  task automatic settle();
    evt_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (MAX_NODES_DEF + 4) @(posedge clk_i);
  endtask

  task automatic write_config(int id, int count);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_NODE_ID;
    cfg_data_i <= CFG_DATA_W'(id);
    @(posedge clk_i);
    sb.node_id = NODE_ID_W'(id);
    cfg_idx_i  <= CFG_NODE_COUNT;
    cfg_data_i <= CFG_DATA_W'(count);
    @(posedge clk_i);
    sb.node_count = COUNT_W'(count);
    cfg_we_i <= 1'b0;
  endtask

  // Stamps cluster around the local clock and the pending request so that ties,
  // wins and losses all come up, with the extremes and full-range values mixed in.
  function automatic logic [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return sb.req_stamp;
      3:       return sb.lclock - STAMP_W'($urandom_range(0, 2));
      4, 5:    return sb.lclock + STAMP_W'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [PEER_W-1:0] pick_peer();
    index_q_t peers;
    peers = sb.peer_list();
    if (peers.size() == 0 || $urandom_range(0, 3) == 0) return PEER_W'($urandom_range(0, 15));
    return PEER_W'(peers[$urandom_range(0, peers.size() - 1)]);
  endfunction

  // One request / replies / release cycle with peer traffic mixed in.
  task automatic protocol_round();
    index_q_t peers;
    int       first;
    peers = sb.peer_list();
    send_event(ACT_REQUEST, PEER_W'($urandom), $urandom());
    first = (peers.size() > 0) ? $urandom_range(0, peers.size() - 1) : 0;
    for (int k = 0; k < peers.size(); k++) begin
      if ($urandom_range(0, 3) == 0) send_event(ACT_PEER_REQ, pick_peer(), pick_stamp());
      if ($urandom_range(0, 15) == 0) send_event(ACT_TICK, PEER_W'($urandom), $urandom());
      send_event(ACT_PEER_REP, PEER_W'(peers[(first + k) % peers.size()]), pick_stamp());
    end
    repeat ($urandom_range(0, 2))
      send_event($urandom_range(0, 1) ? ACT_TICK : ACT_PEER_REQ, pick_peer(), pick_stamp());
    send_event(ACT_RELEASE, PEER_W'($urandom), $urandom());
  endtask

  task automatic run_phase(int id, int count, int quota);
    int target;
    settle();
    write_config(id, count);
    target = sent_items + quota;
    while (sent_items < target) begin
      if ($urandom_range(0, 9) < 7) begin
        protocol_round();
      end else begin
        repeat ($urandom_range(1, 4))
          send_event(ACTION_W'($urandom_range(0, 7)), PEER_W'($urandom_range(0, 15)),
                     pick_stamp());
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    evt_if.valid  = 1'b0;
    evt_if.action = '0;
    evt_if.peer   = '0;
    evt_if.stamp  = '0;
    res_if.ready  = 1'b0;
    idle_en       = 1'b1;
    sent_items    = 0;
    stall_left    = 0;
    quiet_cycles  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: a lone node enters the critical section at once.
    send_event(ACT_TICK, '0, '0);
    send_event(ACT_REQUEST, '0, '0);
    send_event(ACT_REQUEST, '1, '1);
    send_event(ACT_RELEASE, '0, '0);
    send_event(ACT_RELEASE, '1, '1);
    send_event(ACT_PEER_REQ, 4'd0, 32'd7);
    send_event(ACT_PEER_REP, 4'd1, 32'd3);
    send_event(3'd5, 4'd2, '1);
    send_event(3'd6, 4'd9, 32'h5a5a_a5a5);
    send_event(3'd7, '1, '0);

    // Node 1 of 4: peers 0, 2 and 3, so ties go both ways.
    settle();
    write_config(1, 4);
    send_event(ACT_REQUEST, '0, '0);
    send_event(ACT_PEER_REQ, 4'd0, sb.req_stamp - 1);
    send_event(ACT_PEER_REQ, 4'd0, sb.req_stamp);
    send_event(ACT_PEER_REQ, 4'd2, sb.req_stamp);
    send_event(ACT_PEER_REQ, 4'd3, '1);
    send_event(ACT_PEER_REQ, 4'd1, '0);
    send_event(ACT_PEER_REP, 4'd0, '0);
    send_event(ACT_PEER_REP, 4'd2, sb.lclock + 5);
    send_event(ACT_PEER_REP, 4'd3, '0);
    send_event(ACT_PEER_REP, 4'd2, '0);
    send_event(ACT_PEER_REQ, 4'd0, '0);
    send_event(ACT_RELEASE, '0, '0);
    send_event(ACT_PEER_REQ, 4'd3, '0);
    send_event(ACT_PEER_REP, 4'd0, '1);
    send_event(ACT_PEER_REQ, 4'd15, '0);
    send_event(ACT_TICK, '1, '1);

    run_phase(15, 16, 20);
    run_phase(0, 16, 20);
    run_phase(9, 4, 20);
    run_phase(2, 0, 20);
    run_phase(7, 31, 20);
    run_phase(1, 2, 20);
    run_phase(15, 1, 20);
    run_phase(0, 17, 20);
    run_phase($urandom_range(0, 15), $urandom_range(0, 31), 20);
    idle_en = 1'b0;
    run_phase(5, 7, 20);
    settle();

    if (sb.pending() != 0)
      $display("ERROR: %0d expected results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
